/* rtl/ajm_pkg.sv */
package ajm_pkg;

  // Operating mode, priority alarm over join over normal
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_JOIN   = 2'd1,
    MODE_ALARM  = 2'd2
  } mode_t;

  // Event codes; codes above smoke cleared act like none
  typedef enum logic [4:0] {
    EV_NONE          = 5'd0,
    EV_JOIN_ENTER    = 5'd1,
    EV_JOIN_EXIT     = 5'd2,
    EV_JOIN_TIMEOUT  = 5'd3,
    EV_FACTORY_RESET = 5'd4,
    EV_TEST          = 5'd5,
    EV_HOLD_START    = 5'd6,
    EV_HOLD_STOP     = 5'd7,
    EV_JOIN_REQUEST  = 5'd8,
    EV_EXIT          = 5'd9,
    EV_CONFIRM       = 5'd10,
    EV_HEARTBEAT     = 5'd11,
    EV_REMOTE_ON     = 5'd12,
    EV_REMOTE_OFF    = 5'd13,
    EV_REMOTE_SILENCE = 5'd14,
    EV_GATEWAY_LOST  = 5'd15,
    EV_JOIN_ACCEPTED = 5'd16,
    EV_ENTER_OPER    = 5'd17,
    EV_EXIT_GATEWAY  = 5'd18,
    EV_LINK_TEST     = 5'd19,
    EV_SMOKE_ON      = 5'd20,
    EV_SMOKE_OFF     = 5'd21
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] REG_REMOTE_SILENCE = 2'd0;
  localparam logic [1:0] REG_PREJOIN_TEST   = 2'd1;
  localparam logic [1:0] REG_JOIN_SUCCESS   = 2'd2;
  localparam logic [1:0] REG_LINK_TEST      = 2'd3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int ACT_W     = 19;

  // Action bit positions
  localparam int ACT_JOIN_IND   = 0;
  localparam int ACT_STOP_PRE   = 1;
  localparam int ACT_LINK_JOIN  = 2;
  localparam int ACT_LOCAL_WR   = 3;
  localparam int ACT_REMOTE_WR  = 4;
  localparam int ACT_NOTIFY_ON  = 5;
  localparam int ACT_NOTIFY_OFF = 6;
  localparam int ACT_CLR_SIL    = 7;
  localparam int ACT_STORE_RST  = 8;
  localparam int ACT_LINK_INIT  = 9;
  localparam int ACT_JOIN_REQ   = 10;
  localparam int ACT_EXIT_REQ   = 11;
  localparam int ACT_HEARTBEAT  = 12;
  localparam int ACT_SILENCE    = 13;
  localparam int ACT_PREJOIN    = 14;
  localparam int ACT_JOIN_OK    = 15;
  localparam int ACT_LINK_TEST  = 16;
  localparam int ACT_FIRE_REC   = 17;
  localparam int ACT_FLUSH      = 18;

  typedef struct packed {
    logic [4:0]  kind;
    logic        link_joined;
    logic        clock_synced;
    logic        clock_readable;
    logic [31:0] clock_seconds;
  } item_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic             local_alarm_level;
    logic             remote_alarm_level;
    logic             join_active;
    logic [ACT_W-1:0] actions;
    logic [15:0]      duration_seconds;
    logic [31:0]      fire_start_seconds;
  } result_t;

  typedef struct packed {
    mode_t mode;
    logic  local_alarm;
    logic  remote_alarm;
    logic  smoke;
    logic  hold_active;
    logic  join_on;
  } ctrl_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] remote_silence_seconds;
    logic [CFG_W-1:0] prejoin_test_seconds;
    logic [CFG_W-1:0] join_success_seconds;
    logic [CFG_W-1:0] link_test_seconds;
  } cfg_t;

endpackage

/* rtl/ajm_in_if.sv */
interface ajm_in_if;
  import ajm_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ajm_out_if.sv */
interface ajm_out_if;
  import ajm_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/alarm_join_mode_controller_core.sv */
// Channel   Dir  Payload                                          Handshake
// in_ch     in   kind, link_joined, clock_synced, clock_readable,  valid/ready
//                clock_seconds
// out_ch    out  mode, alarm levels, join_active, actions,         valid/ready
//                duration_seconds, fire_start_seconds
// cfg       in   cfg_index, cfg_data                              cfg_we, no wait
//
// One item per cycle sustained while out_ch is ready: an item is held in the
// input register, its flags and result are computed by one shallow decode and
// land in the result register, which drives out_ch. Synchronous active-high
// reset clears the flags, the valid bits and loads the default durations. A
// stalled output holds the result register; the input register takes one more
// item and then holds, dropping in_ch.ready.
module alarm_join_mode_controller_core (
  input  logic                          clk,
  input  logic                          rst,
  ajm_in_if.sink                        in_ch,
  ajm_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ajm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ajm_pkg::CFG_W-1:0]     cfg_data
);
  import ajm_pkg::*;

  ctrl_state_t st;
  ctrl_state_t st_next;
  cfg_t        cfg;
  logic        s1_valid;
  item_t       s1_item;
  logic        out_valid;
  result_t     out_data;
  result_t     res;
  logic        advance;
  logic        in_ready;

  // Move stage one forward whenever the result register is free or draining
  assign advance  = !out_valid || out_ch.ready;
  assign in_ready = !s1_valid || advance;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  ajm_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (s1_item),
    .st_next (st_next),
    .res     (res)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.remote_silence_seconds <= CFG_W'(540);
      cfg.prejoin_test_seconds   <= CFG_W'(8);
      cfg.join_success_seconds   <= CFG_W'(6);
      cfg.link_test_seconds      <= CFG_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REMOTE_SILENCE: cfg.remote_silence_seconds <= cfg_data;
        REG_PREJOIN_TEST:   cfg.prejoin_test_seconds   <= cfg_data;
        REG_JOIN_SUCCESS:   cfg.join_success_seconds   <= cfg_data;
        REG_LINK_TEST:      cfg.link_test_seconds      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) s1_item <= in_ch.data;
  end

  // Controller flags advance with each item leaving stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode: MODE_NORMAL, default: 1'b0};
    end else if (s1_valid && advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) out_data <= res;
  end

endmodule

/* rtl/ajm_step.sv */
module ajm_step (
  input  ajm_pkg::ctrl_state_t st,
  input  ajm_pkg::cfg_t        cfg,
  input  ajm_pkg::item_t       item,
  output ajm_pkg::ctrl_state_t st_next,
  output ajm_pkg::result_t     res
);
  import ajm_pkg::*;

  ctrl_state_t      nxt;
  logic [ACT_W-1:0] acts;
  logic [15:0]      dur;
  logic [31:0]      fire_at;
  mode_t            new_mode;

  always_comb begin
    nxt      = st;
    acts     = '0;
    dur      = '0;
    fire_at  = '0;
    new_mode = MODE_NORMAL;

    // Apply the event to the flags
    unique case (item.kind) inside
      EV_JOIN_ENTER: begin
        if (st.mode != MODE_ALARM && !st.join_on && !item.link_joined) begin
          nxt.join_on = 1'b1;
          acts[ACT_JOIN_IND]  = 1'b1;
          acts[ACT_STOP_PRE]  = 1'b1;
          acts[ACT_LINK_JOIN] = 1'b1;
        end
      end
      EV_JOIN_EXIT, EV_JOIN_TIMEOUT: begin
        if (st.join_on) begin
          nxt.join_on = 1'b0;
          acts[ACT_JOIN_IND]  = 1'b1;
          acts[ACT_LINK_JOIN] = 1'b1;
        end
      end
      EV_FACTORY_RESET: begin
        if (st.mode != MODE_ALARM) begin
          if (st.join_on) begin
            acts[ACT_JOIN_IND]  = 1'b1;
            acts[ACT_LINK_JOIN] = 1'b1;
          end
          nxt.join_on      = 1'b0;
          nxt.hold_active  = 1'b0;
          nxt.smoke        = 1'b0;
          nxt.local_alarm  = 1'b0;
          nxt.remote_alarm = 1'b0;
          acts[ACT_LOCAL_WR]  = 1'b1;
          acts[ACT_REMOTE_WR] = 1'b1;
          acts[ACT_CLR_SIL]   = 1'b1;
          acts[ACT_STORE_RST] = 1'b1;
          acts[ACT_LINK_INIT] = 1'b1;
        end
      end
      EV_TEST: begin
        if (st.mode == MODE_NORMAL && !st.join_on && !item.link_joined) begin
          acts[ACT_PREJOIN] = 1'b1;
          dur = cfg.prejoin_test_seconds;
        end
      end
      EV_HOLD_START: begin
        if (st.mode == MODE_NORMAL && item.link_joined) begin
          nxt.hold_active = 1'b1;
          nxt.local_alarm = 1'b1;
          acts[ACT_LOCAL_WR]  = 1'b1;
          acts[ACT_NOTIFY_ON] = 1'b1;
        end
      end
      EV_HOLD_STOP: begin
        if (st.hold_active) begin
          nxt.hold_active = 1'b0;
          if (!st.smoke) begin
            nxt.local_alarm = 1'b0;
            acts[ACT_LOCAL_WR]   = 1'b1;
            acts[ACT_NOTIFY_OFF] = 1'b1;
          end
        end
      end
      EV_JOIN_REQUEST: begin
        if (st.mode == MODE_NORMAL) acts[ACT_JOIN_REQ] = 1'b1;
      end
      EV_EXIT: begin
        if (st.mode == MODE_NORMAL) acts[ACT_EXIT_REQ] = 1'b1;
      end
      EV_HEARTBEAT: begin
        acts[ACT_HEARTBEAT] = 1'b1;
      end
      EV_REMOTE_ON: begin
        nxt.remote_alarm = 1'b1;
        acts[ACT_REMOTE_WR] = 1'b1;
      end
      EV_REMOTE_OFF: begin
        nxt.remote_alarm = 1'b0;
        acts[ACT_REMOTE_WR] = 1'b1;
        acts[ACT_CLR_SIL]   = 1'b1;
      end
      EV_REMOTE_SILENCE: begin
        acts[ACT_SILENCE] = 1'b1;
        dur = cfg.remote_silence_seconds;
      end
      EV_JOIN_ACCEPTED, EV_ENTER_OPER: begin
        if (st.join_on) begin
          nxt.join_on = 1'b0;
          acts[ACT_JOIN_IND]  = 1'b1;
          acts[ACT_LINK_JOIN] = 1'b1;
          acts[ACT_JOIN_OK]   = 1'b1;
          dur = cfg.join_success_seconds;
        end
      end
      EV_LINK_TEST: begin
        if (st.mode == MODE_NORMAL) begin
          acts[ACT_LINK_TEST] = 1'b1;
          dur = cfg.link_test_seconds;
        end
      end
      EV_SMOKE_ON: begin
        nxt.smoke       = 1'b1;
        nxt.local_alarm = 1'b1;
        acts[ACT_LOCAL_WR]  = 1'b1;
        acts[ACT_NOTIFY_ON] = 1'b1;
      end
      EV_SMOKE_OFF: begin
        nxt.smoke = 1'b0;
        if (!st.hold_active) begin
          nxt.local_alarm = 1'b0;
          acts[ACT_LOCAL_WR]   = 1'b1;
          acts[ACT_NOTIFY_OFF] = 1'b1;
        end
      end
      default: ;
    endcase

    // Derive the mode from the final flags; the mode always tracks the flags
    if (nxt.local_alarm || nxt.remote_alarm) new_mode = MODE_ALARM;
    else if (nxt.join_on)                     new_mode = MODE_JOIN;
    else                                      new_mode = MODE_NORMAL;

    // Record the fire start on alarm entry, flush on alarm to normal
    if (st.mode != MODE_ALARM && new_mode == MODE_ALARM &&
        item.clock_synced && item.clock_readable) begin
      acts[ACT_FIRE_REC] = 1'b1;
      fire_at = item.clock_seconds;
    end
    if (st.mode == MODE_ALARM && new_mode == MODE_NORMAL) acts[ACT_FLUSH] = 1'b1;

    nxt.mode = new_mode;
  end

  assign st_next = nxt;

  assign res.mode               = nxt.mode;
  assign res.local_alarm_level  = nxt.local_alarm;
  assign res.remote_alarm_level = nxt.remote_alarm;
  assign res.join_active        = nxt.join_on;
  assign res.actions            = acts;
  assign res.duration_seconds   = dur;
  assign res.fire_start_seconds = fire_at;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ajm_pkg::*;

  localparam logic [CFG_W-1:0] DEF_SILENCE   = 16'd540;
  localparam logic [CFG_W-1:0] DEF_PREJOIN   = 16'd8;
  localparam logic [CFG_W-1:0] DEF_JOIN_OK   = 16'd6;
  localparam logic [CFG_W-1:0] DEF_LINK_TEST = 16'd10;
  localparam logic [4:0]       KIND_UNDEF    = 5'd31;
  localparam int               STALL_LIMIT   = 2000;
  localparam int               HOLD_CYCLES   = 300;
  localparam int               TAIL_CYCLES   = 8;

  // One event to offer, with a hand-written result where it is obvious
  typedef struct {
    item_t   ev;
    bit      typed;
    result_t res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  logic calm;
  logic hold_trigger;
  logic hold_done;
  int hold_left;
  int stuck;
  int errors = 0;

  plan_row_t offered_events[$];
  result_t pending_results[$];

  // Shadow of the controller flags and durations
  ctrl_state_t ctl;
  cfg_t dur_cfg;
  item_t step_in;
  logic [ACT_W-1:0] step_acts;
  logic [15:0] step_dur;
  logic [31:0] step_fire;

  ajm_in_if in_ch ();
  ajm_out_if out_ch ();

  alarm_join_mode_controller_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [ACT_W-1:0] act_bit(int b);
    logic [ACT_W-1:0] m;
    m = '0;
    m[b] = 1'b1;
    return m;
  endfunction

  function automatic item_t mk_ev(logic [4:0] kind, logic joined, logic synced,
                                  logic readable, logic [31:0] secs);
    item_t e;
    e.kind = kind;
    e.link_joined = joined;
    e.clock_synced = synced;
    e.clock_readable = readable;
    e.clock_seconds = secs;
    return e;
  endfunction

  function automatic result_t mk_res(mode_t m, logic loc, logic rem, logic jn,
                                     logic [ACT_W-1:0] acts, logic [15:0] d,
                                     logic [31:0] f);
    result_t r;
    r.mode = m;
    r.local_alarm_level = loc;
    r.remote_alarm_level = rem;
    r.join_active = jn;
    r.actions = acts;
    r.duration_seconds = d;
    r.fire_start_seconds = f;
    return r;
  endfunction

  // Recompute the mode; note fire start on alarm entry, flush on alarm to normal
  function automatic void rederive_mode();
    mode_t prior;
    prior = ctl.mode;
    if (ctl.local_alarm || ctl.remote_alarm) begin
      ctl.mode = MODE_ALARM;
    end else if (ctl.join_on) begin
      ctl.mode = MODE_JOIN;
    end else begin
      ctl.mode = MODE_NORMAL;
    end
    if (prior != MODE_ALARM && ctl.mode == MODE_ALARM &&
        step_in.clock_synced && step_in.clock_readable) begin
      step_acts[ACT_FIRE_REC] = 1'b1;
      step_fire = step_in.clock_seconds;
    end
    if (prior == MODE_ALARM && ctl.mode == MODE_NORMAL) begin
      step_acts[ACT_FLUSH] = 1'b1;
    end
  endfunction

  // Change the join flag; drop a no-op or a set while the link is joined
  function automatic void set_join(logic v);
    if (v == ctl.join_on) return;
    if (v && step_in.link_joined) return;
    ctl.join_on = v;
    step_acts[ACT_JOIN_IND] = 1'b1;
    step_acts[ACT_LINK_JOIN] = 1'b1;
    if (v) step_acts[ACT_STOP_PRE] = 1'b1;
    rederive_mode();
  endfunction

  function automatic void set_local(logic v);
    ctl.local_alarm = v;
    step_acts[ACT_LOCAL_WR] = 1'b1;
    rederive_mode();
  endfunction

  function automatic void set_remote(logic v);
    ctl.remote_alarm = v;
    step_acts[ACT_REMOTE_WR] = 1'b1;
    rederive_mode();
  endfunction

  // Apply one event to the shadow state and build its result
  function automatic result_t advance_controller(item_t it);
    step_in = it;
    step_acts = '0;
    step_dur = '0;
    step_fire = '0;
    case (it.kind) inside
      EV_JOIN_ENTER: begin
        if (ctl.mode != MODE_ALARM) set_join(1'b1);
      end
      EV_JOIN_EXIT: set_join(1'b0);
      EV_JOIN_TIMEOUT: begin
        if (ctl.join_on) set_join(1'b0);
      end
      EV_FACTORY_RESET: begin
        if (ctl.mode != MODE_ALARM) begin
          set_join(1'b0);
          ctl.hold_active = 1'b0;
          ctl.smoke = 1'b0;
          set_local(1'b0);
          set_remote(1'b0);
          step_acts[ACT_CLR_SIL] = 1'b1;
          step_acts[ACT_STORE_RST] = 1'b1;
          step_acts[ACT_LINK_INIT] = 1'b1;
        end
      end
      EV_TEST: begin
        if (ctl.mode == MODE_NORMAL && !ctl.join_on && !it.link_joined) begin
          step_acts[ACT_PREJOIN] = 1'b1;
          step_dur = dur_cfg.prejoin_test_seconds;
        end
      end
      EV_HOLD_START: begin
        if (ctl.mode == MODE_NORMAL && it.link_joined) begin
          ctl.hold_active = 1'b1;
          set_local(1'b1);
          step_acts[ACT_NOTIFY_ON] = 1'b1;
        end
      end
      EV_HOLD_STOP: begin
        if (ctl.hold_active) begin
          ctl.hold_active = 1'b0;
          if (!ctl.smoke) begin
            set_local(1'b0);
            step_acts[ACT_NOTIFY_OFF] = 1'b1;
          end
        end
      end
      EV_JOIN_REQUEST: begin
        if (ctl.mode == MODE_NORMAL) step_acts[ACT_JOIN_REQ] = 1'b1;
      end
      EV_EXIT: begin
        if (ctl.mode == MODE_NORMAL) step_acts[ACT_EXIT_REQ] = 1'b1;
      end
      EV_HEARTBEAT: step_acts[ACT_HEARTBEAT] = 1'b1;
      EV_REMOTE_ON: set_remote(1'b1);
      EV_REMOTE_OFF: begin
        set_remote(1'b0);
        step_acts[ACT_CLR_SIL] = 1'b1;
      end
      EV_REMOTE_SILENCE: begin
        step_acts[ACT_SILENCE] = 1'b1;
        step_dur = dur_cfg.remote_silence_seconds;
      end
      EV_JOIN_ACCEPTED, EV_ENTER_OPER: begin
        if (ctl.join_on) begin
          set_join(1'b0);
          step_acts[ACT_JOIN_OK] = 1'b1;
          step_dur = dur_cfg.join_success_seconds;
        end
      end
      EV_LINK_TEST: begin
        if (ctl.mode == MODE_NORMAL) begin
          step_acts[ACT_LINK_TEST] = 1'b1;
          step_dur = dur_cfg.link_test_seconds;
        end
      end
      EV_SMOKE_ON: begin
        ctl.smoke = 1'b1;
        set_local(1'b1);
        step_acts[ACT_NOTIFY_ON] = 1'b1;
      end
      EV_SMOKE_OFF: begin
        ctl.smoke = 1'b0;
        if (!ctl.hold_active) begin
          set_local(1'b0);
          step_acts[ACT_NOTIFY_OFF] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return mk_res(ctl.mode, ctl.local_alarm, ctl.remote_alarm, ctl.join_on,
                  step_acts, step_dur, step_fire);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Random event: mostly defined kinds, clock mostly valid, edge epochs now and then
  function automatic item_t rand_ev();
    item_t e;
    if ($urandom_range(99) < 5) begin
      e.kind = 5'($urandom_range(31, 22));
    end else begin
      e.kind = 5'($urandom_range(21, 0));
    end
    e.link_joined = 1'($urandom_range(1));
    e.clock_synced = ($urandom_range(3) != 0);
    e.clock_readable = ($urandom_range(3) != 0);
    case ($urandom_range(9))
      0: e.clock_seconds = '0;
      1: e.clock_seconds = '1;
      default: e.clock_seconds = $urandom();
    endcase
    return e;
  endfunction

  // Track accepted items, check results, watch for a hang
  always @(posedge clk) begin
    plan_row_t row;
    result_t want;
    result_t got;
    if (rst) begin
      ctl = '{mode: MODE_NORMAL, default: 1'b0};
      stuck = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        want = advance_controller(in_ch.data);
        row = offered_events.pop_front();
        if (row.typed) want = row.res;
        pending_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_results.size() == 0) begin
          $error("result item with no event pending");
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("mode", 32'(want.mode), 32'(got.mode));
          check_field("local_alarm_level", 32'(want.local_alarm_level),
                      32'(got.local_alarm_level));
          check_field("remote_alarm_level", 32'(want.remote_alarm_level),
                      32'(got.remote_alarm_level));
          check_field("join_active", 32'(want.join_active), 32'(got.join_active));
          check_field("actions", 32'(want.actions), 32'(got.actions));
          check_field("duration_seconds", 32'(want.duration_seconds),
                      32'(got.duration_seconds));
          check_field("fire_start_seconds", want.fire_start_seconds,
                      got.fire_start_seconds);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
      if (stuck >= STALL_LIMIT) begin
        $display("alarm_join_mode_controller_core test failed");
        $finish;
      end
    end
  end

  // Result side: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_trigger && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  // Offer one event and hold it until accepted
  task automatic offer(plan_row_t r);
    if (!calm && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    offered_events.push_back(r);
    in_ch.valid <= 1'b1;
    in_ch.data <= r.ev;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait for every result to come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic program_durations(logic [CFG_W-1:0] v0, logic [CFG_W-1:0] v1,
                                   logic [CFG_W-1:0] v2, logic [CFG_W-1:0] v3);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0] val [4];
    idx = '{REG_REMOTE_SILENCE, REG_PREJOIN_TEST, REG_JOIN_SUCCESS, REG_LINK_TEST};
    val = '{v0, v1, v2, v3};
    for (int k = 0; k < 4; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      case (idx[k])
        REG_REMOTE_SILENCE: dur_cfg.remote_silence_seconds = val[k];
        REG_PREJOIN_TEST:   dur_cfg.prejoin_test_seconds = val[k];
        REG_JOIN_SUCCESS:   dur_cfg.join_success_seconds = val[k];
        REG_LINK_TEST:      dur_cfg.link_test_seconds = val[k];
        default: begin
        end
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n, bit stall_mid);
    for (int k = 0; k < n; k++) begin
      if (stall_mid && k == n / 2) hold_trigger <= 1'b1;
      offer('{rand_ev(), 1'b0, '0});
    end
  endtask

  initial begin
    plan_row_t directed[$];
    dur_cfg = '{DEF_SILENCE, DEF_PREJOIN, DEF_JOIN_OK, DEF_LINK_TEST};
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    calm <= 1'b0;
    hold_trigger <= 1'b0;

    // Idle events from reset: results read straight off the defaults
    directed.push_back('{mk_ev(EV_NONE, 1'b0, 1'b0, 1'b0, '0), 1'b1,
                         mk_res(MODE_NORMAL, 1'b0, 1'b0, 1'b0, '0, '0, '0)});
    directed.push_back('{mk_ev(EV_TEST, 1'b0, 1'b1, 1'b1, 32'h1), 1'b1,
                         mk_res(MODE_NORMAL, 1'b0, 1'b0, 1'b0, act_bit(ACT_PREJOIN),
                                DEF_PREJOIN, '0)});
    directed.push_back('{mk_ev(EV_HEARTBEAT, 1'b1, 1'b1, 1'b1, '1), 1'b1,
                         mk_res(MODE_NORMAL, 1'b0, 1'b0, 1'b0, act_bit(ACT_HEARTBEAT),
                                '0, '0)});
    directed.push_back('{mk_ev(EV_REMOTE_SILENCE, 1'b0, 1'b0, 1'b0, '0), 1'b1,
                         mk_res(MODE_NORMAL, 1'b0, 1'b0, 1'b0, act_bit(ACT_SILENCE),
                                DEF_SILENCE, '0)});
    directed.push_back('{mk_ev(EV_LINK_TEST, 1'b1, 1'b0, 1'b0, '0), 1'b1,
                         mk_res(MODE_NORMAL, 1'b0, 1'b0, 1'b0, act_bit(ACT_LINK_TEST),
                                DEF_LINK_TEST, '0)});
    directed.push_back('{mk_ev(EV_JOIN_REQUEST, 1'b0, 1'b0, 1'b0, '0), 1'b1,
                         mk_res(MODE_NORMAL, 1'b0, 1'b0, 1'b0, act_bit(ACT_JOIN_REQ),
                                '0, '0)});
    directed.push_back('{mk_ev(EV_CONFIRM, 1'b1, 1'b1, 1'b1, '1), 1'b1,
                         mk_res(MODE_NORMAL, 1'b0, 1'b0, 1'b0, '0, '0, '0)});
    directed.push_back('{mk_ev(KIND_UNDEF, 1'b1, 1'b1, 1'b1, '1), 1'b1,
                         mk_res(MODE_NORMAL, 1'b0, 1'b0, 1'b0, '0, '0, '0)});
    // Join refused while the link is joined, then taken
    directed.push_back('{mk_ev(EV_JOIN_ENTER, 1'b1, 1'b0, 1'b0, '0), 1'b1,
                         mk_res(MODE_NORMAL, 1'b0, 1'b0, 1'b0, '0, '0, '0)});
    directed.push_back('{mk_ev(EV_JOIN_ENTER, 1'b0, 1'b0, 1'b0, '0), 1'b1,
                         mk_res(MODE_JOIN, 1'b0, 1'b0, 1'b1,
                                act_bit(ACT_JOIN_IND) | act_bit(ACT_STOP_PRE) |
                                act_bit(ACT_LINK_JOIN), '0, '0)});
    // Leave join through operation entry, then through timeout
    directed.push_back('{mk_ev(EV_ENTER_OPER, 1'b0, 1'b0, 1'b0, '0), 1'b0, '0});
    directed.push_back('{mk_ev(EV_JOIN_ENTER, 1'b0, 1'b0, 1'b0, '0), 1'b0, '0});
    directed.push_back('{mk_ev(EV_JOIN_TIMEOUT, 1'b0, 1'b0, 1'b0, '0), 1'b0, '0});
    // Smoke alarm with fire start, refused events in alarm, both alarms cleared
    directed.push_back('{mk_ev(EV_SMOKE_ON, 1'b0, 1'b1, 1'b1, '1), 1'b0, '0});
    directed.push_back('{mk_ev(EV_JOIN_ENTER, 1'b0, 1'b1, 1'b1, '0), 1'b0, '0});
    directed.push_back('{mk_ev(EV_FACTORY_RESET, 1'b0, 1'b1, 1'b1, '0), 1'b0, '0});
    directed.push_back('{mk_ev(EV_REMOTE_ON, 1'b0, 1'b1, 1'b1, '0), 1'b0, '0});
    directed.push_back('{mk_ev(EV_SMOKE_OFF, 1'b0, 1'b1, 1'b1, '0), 1'b0, '0});
    directed.push_back('{mk_ev(EV_REMOTE_OFF, 1'b0, 1'b1, 1'b1, '0), 1'b0, '0});
    // Test hold with an unsynced clock, smoke keeping the local alarm on
    directed.push_back('{mk_ev(EV_HOLD_START, 1'b1, 1'b0, 1'b1, 32'h5a5a_a5a5), 1'b0,
                         '0});
    directed.push_back('{mk_ev(EV_SMOKE_ON, 1'b1, 1'b1, 1'b1, '0), 1'b0, '0});
    directed.push_back('{mk_ev(EV_HOLD_STOP, 1'b1, 1'b1, 1'b1, '0), 1'b0, '0});
    directed.push_back('{mk_ev(EV_SMOKE_OFF, 1'b1, 1'b1, 1'b1, '0), 1'b0, '0});
    // Alarm from join mode and back to join, then factory reset out of join
    directed.push_back('{mk_ev(EV_JOIN_ENTER, 1'b0, 1'b0, 1'b0, '0), 1'b0, '0});
    directed.push_back('{mk_ev(EV_REMOTE_ON, 1'b0, 1'b1, 1'b1, 32'h8000_0000), 1'b0,
                         '0});
    directed.push_back('{mk_ev(EV_REMOTE_OFF, 1'b0, 1'b1, 1'b1, '0), 1'b0, '0});
    directed.push_back('{mk_ev(EV_FACTORY_RESET, 1'b0, 1'b0, 1'b0, '0), 1'b0, '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) offer(directed[k]);
    run_random(200, 1'b0);
    settle();

    // Zero durations, with one long result-side hold-off
    program_durations('0, '0, '0, '0);
    run_random(200, 1'b1);
    settle();

    // Full-scale durations, no idling on either side
    program_durations('1, '1, '1, '1);
    calm <= 1'b1;
    run_random(200, 1'b0);
    settle();
    calm <= 1'b0;

    repeat (2) begin
      program_durations(16'($urandom()), 16'($urandom()), 16'($urandom()),
                        16'($urandom()));
      run_random(200, 1'b0);
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("alarm_join_mode_controller_core test passed");
    end else begin
      $display("alarm_join_mode_controller_core test failed");
    end
    $finish;
  end

endmodule
